### rtl/elzr_pkg.sv
// Shared types and constants for the eight-zone line rasterizer.
`timescale 1ns / 1ps

package elzr_pkg;

    localparam int C_COORD_BITS  = 12;
    localparam int C_QUEUE_DEPTH = 2;

    typedef enum logic {
        OP_START = 1'b0,
        OP_STEP  = 1'b1
    } t_op;

    typedef enum logic [2:0] {
        ZONE_0 = 3'd0,
        ZONE_1 = 3'd1,
        ZONE_2 = 3'd2,
        ZONE_3 = 3'd3,
        ZONE_4 = 3'd4,
        ZONE_5 = 3'd5,
        ZONE_6 = 3'd6,
        ZONE_7 = 3'd7
    } t_zone;

    typedef struct packed {
        t_op   op;
        t_zone zone;
    } t_cmd_hdr;

    localparam int C_HDR_W = $bits(t_cmd_hdr);

endpackage

### rtl/elzr_front.sv
// Front end: input register, zone classification and mapping into zone 0.
`timescale 1ns / 1ps

module elzr_front #(
    parameter int COORD_BITS = 12
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_valid,
    output logic                  o_ready,
    input  elzr_pkg::t_op         i_op,
    input  logic [COORD_BITS-1:0] i_x0,
    input  logic [COORD_BITS-1:0] i_y0,
    input  logic [COORD_BITS-1:0] i_x1,
    input  logic [COORD_BITS-1:0] i_y1,
    output logic                  o_push,
    input  logic                  i_q_ready,
    output logic [elzr_pkg::C_HDR_W+5*(COORD_BITS+1)-1:0] o_entry
);
    import elzr_pkg::*;

    localparam int W = COORD_BITS + 1;

    logic                         r_valid;
    t_op                          r_op;
    logic signed [COORD_BITS-1:0] r_x0, r_y0, r_x1, r_y1;
    logic signed [W-1:0]          r_dx, r_dy;

    logic signed [W-1:0] n_dx, n_dy;
    logic signed [W-1:0] adx, ady;
    logic signed [W-1:0] ex0, ey0, ex1, ey1;
    logic signed [W-1:0] a0, b0, a1, da, db;
    logic                ge;
    t_zone               zone;
    t_cmd_hdr            hdr;

    assign n_dx = W'($signed(i_x1)) - W'($signed(i_x0));
    assign n_dy = W'($signed(i_y1)) - W'($signed(i_y0));

    assign o_push  = r_valid && i_q_ready;
    assign o_ready = !r_valid || i_q_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
        if (o_ready && i_valid) begin
            r_op <= i_op;
            r_x0 <= $signed(i_x0);
            r_y0 <= $signed(i_y0);
            r_x1 <= $signed(i_x1);
            r_y1 <= $signed(i_y1);
            r_dx <= n_dx;
            r_dy <= n_dy;
        end
    end

    assign adx = r_dx[W-1] ? -r_dx : r_dx;
    assign ady = r_dy[W-1] ? -r_dy : r_dy;
    assign ge  = adx >= ady;

    always_comb begin
        unique case ({r_dx[W-1], r_dy[W-1]})
            2'b00:   zone = ge ? ZONE_0 : ZONE_1;
            2'b10:   zone = ge ? ZONE_3 : ZONE_2;
            2'b11:   zone = ge ? ZONE_4 : ZONE_5;
            default: zone = ge ? ZONE_7 : ZONE_6;
        endcase
    end

    assign ex0 = W'(r_x0);
    assign ey0 = W'(r_y0);
    assign ex1 = W'(r_x1);
    assign ey1 = W'(r_y1);

    // da/db follow from the mapped difference, since the mapping is linear
    always_comb begin
        unique case (zone)
            ZONE_0: begin
                a0 = ex0;  b0 = ey0;  a1 = ex1;  da = r_dx;  db = r_dy;
            end
            ZONE_1: begin
                a0 = ey0;  b0 = ex0;  a1 = ey1;  da = r_dy;  db = r_dx;
            end
            ZONE_2: begin
                a0 = ey0;  b0 = -ex0; a1 = ey1;  da = r_dy;  db = -r_dx;
            end
            ZONE_3: begin
                a0 = -ex0; b0 = ey0;  a1 = -ex1; da = -r_dx; db = r_dy;
            end
            ZONE_4: begin
                a0 = -ex0; b0 = -ey0; a1 = -ex1; da = -r_dx; db = -r_dy;
            end
            ZONE_5: begin
                a0 = -ey0; b0 = -ex0; a1 = -ey1; da = -r_dy; db = -r_dx;
            end
            ZONE_6: begin
                a0 = -ey0; b0 = ex0;  a1 = -ey1; da = -r_dy; db = r_dx;
            end
            default: begin
                a0 = ex0;  b0 = -ey0; a1 = ex1;  da = r_dx;  db = -r_dy;
            end
        endcase
    end

    assign hdr.op   = r_op;
    assign hdr.zone = zone;

    assign o_entry = {hdr, a0, b0, a1, da, db};

endmodule

### rtl/elzr_fifo.sv
// Short command queue between the front end and the stepping back end.
`timescale 1ns / 1ps

module elzr_fifo #(
    parameter int DATA_W = 69,
    parameter int DEPTH  = 2
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    output logic              o_ready,
    input  logic [DATA_W-1:0] i_data,
    output logic              o_valid,
    input  logic              i_pop,
    output logic [DATA_W-1:0] o_data
);
    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [DATA_W-1:0] r_slot [DEPTH];
    logic [PTR_W-1:0]  r_wptr, r_rptr;
    logic [CNT_W-1:0]  r_count;
    logic              do_push, do_pop;

    assign o_valid = r_count != '0;
    assign o_ready = (r_count != CNT_W'(DEPTH)) || i_pop;
    assign o_data  = r_slot[r_rptr];
    assign do_push = i_push && o_ready;
    assign do_pop  = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            if (do_push) begin
                r_wptr <= (r_wptr == PTR_W'(DEPTH - 1)) ? '0 : r_wptr + 1'b1;
            end
            if (do_pop) begin
                r_rptr <= (r_rptr == PTR_W'(DEPTH - 1)) ? '0 : r_rptr + 1'b1;
            end
            r_count <= r_count + CNT_W'(do_push) - CNT_W'(do_pop);
        end
        if (do_push) begin
            r_slot[r_wptr] <= i_data;
        end
    end

endmodule

### rtl/elzr_back.sv
// Back end: midpoint decision state, pixel mapping and output register.
`timescale 1ns / 1ps

module elzr_back #(
    parameter int COORD_BITS = 12
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_q_valid,
    input  logic [elzr_pkg::C_HDR_W+5*(COORD_BITS+1)-1:0] i_q_data,
    output logic                  o_pop,
    output logic                  o_valid,
    input  logic                  i_ready,
    output logic [COORD_BITS-1:0] o_px,
    output logic [COORD_BITS-1:0] o_py,
    output logic [2:0]            o_zone,
    output logic                  o_last
);
    import elzr_pkg::*;

    localparam int W    = COORD_BITS + 1;
    localparam int SE_W = COORD_BITS + 2;
    localparam int D    = COORD_BITS + 3;

    t_cmd_hdr            hdr;
    logic signed [W-1:0] q_a0, q_b0, q_a1, q_da, q_db;
    logic signed [D-1:0] q_da_x, q_db_x;

    logic                   r_active;
    logic signed [W-1:0]    r_major, r_minor, r_end;
    logic signed [D-1:0]    r_dec, r_sd;
    logic signed [SE_W-1:0] r_se;
    t_zone                  r_zone;

    logic                   r_out_valid;
    logic [COORD_BITS-1:0]  r_px, r_py;
    t_zone                  r_out_zone;
    logic                   r_out_last;

    logic                   is_start, emit;
    t_zone                  cur_zone;
    logic signed [W-1:0]    cur_major, cur_minor, cur_end;
    logic signed [D-1:0]    cur_dec, cur_sd;
    logic signed [SE_W-1:0] cur_se;
    logic                   last;
    logic signed [W-1:0]    px_w, py_w;

    assign {hdr, q_a0, q_b0, q_a1, q_da, q_db} = i_q_data;
    assign q_da_x = D'(q_da);
    assign q_db_x = D'(q_db);

    assign o_pop    = i_q_valid && (!r_out_valid || i_ready);
    assign is_start = hdr.op == OP_START;
    assign emit     = o_pop && (is_start || r_active);

    // a start feeds its fresh state straight into the shared emit path
    always_comb begin
        if (is_start) begin
            cur_zone  = hdr.zone;
            cur_major = q_a0;
            cur_minor = q_b0;
            cur_end   = q_a1;
            cur_dec   = (q_db_x <<< 1) - q_da_x;
            cur_se    = SE_W'(q_db_x <<< 1);
            cur_sd    = (q_db_x - q_da_x) <<< 1;
        end else begin
            cur_zone  = r_zone;
            cur_major = r_major;
            cur_minor = r_minor;
            cur_end   = r_end;
            cur_dec   = r_dec;
            cur_se    = r_se;
            cur_sd    = r_sd;
        end
    end

    assign last = cur_major >= cur_end;

    always_comb begin
        unique case (cur_zone)
            ZONE_0:  begin px_w = cur_major;  py_w = cur_minor;  end
            ZONE_1:  begin px_w = cur_minor;  py_w = cur_major;  end
            ZONE_2:  begin px_w = -cur_minor; py_w = cur_major;  end
            ZONE_3:  begin px_w = -cur_major; py_w = cur_minor;  end
            ZONE_4:  begin px_w = -cur_major; py_w = -cur_minor; end
            ZONE_5:  begin px_w = -cur_minor; py_w = -cur_major; end
            ZONE_6:  begin px_w = cur_minor;  py_w = -cur_major; end
            default: begin px_w = cur_major;  py_w = -cur_minor; end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active    <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (emit) begin
                r_active    <= !last;
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
        if (emit) begin
            r_zone     <= cur_zone;
            r_end      <= cur_end;
            r_se       <= cur_se;
            r_sd       <= cur_sd;
            r_major    <= cur_major + W'(1);
            if (cur_dec[D-1]) begin
                r_minor <= cur_minor;
                r_dec   <= cur_dec + D'(cur_se);
            end else begin
                r_minor <= cur_minor + W'(1);
                r_dec   <= cur_dec + cur_sd;
            end
            r_px       <= px_w[COORD_BITS-1:0];
            r_py       <= py_w[COORD_BITS-1:0];
            r_out_zone <= cur_zone;
            r_out_last <= last;
        end
    end

    assign o_valid = r_out_valid;
    assign o_px    = r_px;
    assign o_py    = r_py;
    assign o_zone  = r_out_zone;
    assign o_last  = r_out_last;

endmodule

### rtl/eight_zone_line_rasterizer.sv
// Top level of the eight-zone midpoint line rasterizer.
// A start transaction (tuser = 0) classifies the line into one of eight zones and
// returns its first pixel; each step transaction (tuser = 1) returns the next pixel,
// with tlast on the final endpoint. Steps with no active line return nothing, and a
// start abandons any line in progress. One transaction is taken per clock unless the
// queue is full and stalls the front end; a pixel passes through the front register,
// queue slot and output register, and the two-entry queue between classifier and
// stepper lets either side stall alone.
`timescale 1ns / 1ps

module eight_zone_line_rasterizer #(
    parameter int COORD_BITS  = elzr_pkg::C_COORD_BITS,
    parameter int QUEUE_DEPTH = elzr_pkg::C_QUEUE_DEPTH,
    localparam int S_DATA_W   = ((4 * COORD_BITS + 7) / 8) * 8,
    localparam int M_DATA_W   = ((2 * COORD_BITS + 3 + 7) / 8) * 8
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                s_axis_tvalid,
    output logic                s_axis_tready,
    // start_x, start_y, end_x, end_y
    input  logic [S_DATA_W-1:0] s_axis_tdata,
    // op
    input  logic [0:0]          s_axis_tuser,
    output logic                m_axis_tvalid,
    input  logic                m_axis_tready,
    // pixel_x, pixel_y, octant
    output logic [M_DATA_W-1:0] m_axis_tdata,
    // last_pixel
    output logic                m_axis_tlast
);
    import elzr_pkg::*;

    localparam int ENTRY_W = C_HDR_W + 5 * (COORD_BITS + 1);
    localparam int PAD_W   = M_DATA_W - (2 * COORD_BITS + 3);

    logic                  q_push, q_ready, q_valid, q_pop;
    logic [ENTRY_W-1:0]    q_wdata, q_rdata;
    logic [COORD_BITS-1:0] px, py;
    logic [2:0]            zone;

    elzr_front #(
        .COORD_BITS(COORD_BITS)
    ) u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (s_axis_tvalid),
        .o_ready  (s_axis_tready),
        .i_op     (t_op'(s_axis_tuser)),
        .i_x0     (s_axis_tdata[COORD_BITS-1:0]),
        .i_y0     (s_axis_tdata[2*COORD_BITS-1:COORD_BITS]),
        .i_x1     (s_axis_tdata[3*COORD_BITS-1:2*COORD_BITS]),
        .i_y1     (s_axis_tdata[4*COORD_BITS-1:3*COORD_BITS]),
        .o_push   (q_push),
        .i_q_ready(q_ready),
        .o_entry  (q_wdata)
    );

    elzr_fifo #(
        .DATA_W(ENTRY_W),
        .DEPTH (QUEUE_DEPTH)
    ) u_fifo (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_push (q_push),
        .o_ready(q_ready),
        .i_data (q_wdata),
        .o_valid(q_valid),
        .i_pop  (q_pop),
        .o_data (q_rdata)
    );

    elzr_back #(
        .COORD_BITS(COORD_BITS)
    ) u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_q_valid(q_valid),
        .i_q_data (q_rdata),
        .o_pop    (q_pop),
        .o_valid  (m_axis_tvalid),
        .i_ready  (m_axis_tready),
        .o_px     (px),
        .o_py     (py),
        .o_zone   (zone),
        .o_last   (m_axis_tlast)
    );

    assign m_axis_tdata = {PAD_W'(0), zone, py, px};

endmodule

### rtl/elzr_checker.sv
// Port-level checks for the line rasterizer, bound to the top level.
`timescale 1ns / 1ps

module elzr_checker #(
    parameter int COORD_BITS = 12,
    localparam int M_DATA_W  = ((2 * COORD_BITS + 3 + 7) / 8) * 8
) (
    input logic                i_clk,
    input logic                i_rst_n,
    input logic                s_axis_tready,
    input logic                m_axis_tvalid,
    input logic                m_axis_tready,
    input logic [M_DATA_W-1:0] m_axis_tdata,
    input logic                m_axis_tlast
);

    a_out_idle_after_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid)
        else $error("output valid right after reset");

    a_in_ready_after_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> s_axis_tready)
        else $error("input not ready right after reset");

    a_out_valid_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
        else $error("output transaction dropped while stalled");

    a_out_data_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata) && $stable(m_axis_tlast))
        else $error("output payload changed while stalled");

endmodule

bind eight_zone_line_rasterizer elzr_checker #(
    .COORD_BITS(COORD_BITS)
) u_elzr_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .s_axis_tready(s_axis_tready),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tlast (m_axis_tlast)
);
